// ----- rtl/core/rpnp_pkg.sv -----
// ----------------------------------------------------------------------------
// rpnp_pkg
// Shared types, constants and the digit decoder of the radix-prefixed
// number parser.
// ----------------------------------------------------------------------------
package rpnp_pkg;

    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned RADIX_W   = 5;

    localparam logic [RADIX_W-1:0] RADIX_HEX        = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_DEC        = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_OCT        = 5'd8;
    localparam logic [RADIX_W-1:0] RADIX_RESET      = RADIX_HEX;
    localparam logic [RADIX_W-1:0] RADIX_NONE       = 5'd0;
    // Digit code for a character that is not one of the sixteen digit symbols.
    localparam logic [RADIX_W-1:0] DIGIT_NONE       = 5'd16;
    localparam logic [CHAR_W-1:0]  DIGIT_ALPHA_BASE = 8'h0A;

    localparam logic [CHAR_W-1:0] CHAR_TERM    = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_X = 8'h58;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_X = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_N = 8'h4E;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_N = 8'h6E;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_O = 8'h4F;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_O = 8'h6F;

    typedef enum logic [1:0] {
        POS_FIRST,
        POS_SECOND,
        POS_LATER
    } char_pos_t;

    typedef struct packed {
        logic [VALUE_W-1:0] accumulator;
        logic [RADIX_W-1:0] active_radix;
        char_pos_t          char_position;
        logic               leading_zero_seen;
        logic               stopped;
    } parse_state_t;

    // Value 0..15 of a digit symbol, DIGIT_NONE for anything else.
    function automatic logic [RADIX_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [RADIX_W-1:0] d;
        d = DIGIT_NONE;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = RADIX_W'(c - CHAR_ZERO);
        end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            d = RADIX_W'(c - CHAR_UPPER_A + DIGIT_ALPHA_BASE);
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
            d = RADIX_W'(c - CHAR_LOWER_A + DIGIT_ALPHA_BASE);
        end
        return d;
    endfunction

endpackage

// ----- rtl/core/rpnp_step.sv -----
// ----------------------------------------------------------------------------
// rpnp_step
// Next-state logic for one character: prefix detection, digit check and
// the accumulator multiply-add.
// ----------------------------------------------------------------------------
module rpnp_step (
    input  logic [rpnp_pkg::CHAR_W-1:0]  char_code,
    input  logic [rpnp_pkg::RADIX_W-1:0] default_radix,
    input  rpnp_pkg::parse_state_t       state_cur,
    output rpnp_pkg::parse_state_t       state_next,
    output logic                         is_term
);

    always_comb begin
        logic                         take_en;
        logic [rpnp_pkg::RADIX_W-1:0] take_radix;
        logic [rpnp_pkg::RADIX_W-1:0] digit;
        logic                         is_x;
        logic                         is_n;
        logic                         is_o;

        state_next = state_cur;
        take_en    = 1'b0;
        take_radix = state_cur.active_radix;
        digit      = rpnp_pkg::digit_of(char_code);
        is_term    = (char_code == rpnp_pkg::CHAR_TERM);
        is_x = (char_code == rpnp_pkg::CHAR_UPPER_X) || (char_code == rpnp_pkg::CHAR_LOWER_X);
        is_n = (char_code == rpnp_pkg::CHAR_UPPER_N) || (char_code == rpnp_pkg::CHAR_LOWER_N);
        is_o = (char_code == rpnp_pkg::CHAR_UPPER_O) || (char_code == rpnp_pkg::CHAR_LOWER_O);

        if (is_term) begin
            state_next.accumulator       = '0;
            state_next.active_radix      = default_radix;
            state_next.char_position     = rpnp_pkg::POS_FIRST;
            state_next.leading_zero_seen = 1'b0;
            state_next.stopped           = 1'b0;
        end else begin
            unique case (state_cur.char_position)
                rpnp_pkg::POS_FIRST: begin
                    // The default radix is sampled on the first character only.
                    state_next.active_radix  = default_radix;
                    state_next.char_position = rpnp_pkg::POS_SECOND;
                    take_radix               = default_radix;
                    if (char_code == rpnp_pkg::CHAR_ZERO) begin
                        state_next.leading_zero_seen = 1'b1;
                    end else begin
                        take_en = 1'b1;
                    end
                end
                rpnp_pkg::POS_SECOND: begin
                    state_next.char_position = rpnp_pkg::POS_LATER;
                    if (state_cur.leading_zero_seen) begin
                        state_next.leading_zero_seen = 1'b0;
                        priority if (is_x) begin
                            state_next.active_radix = rpnp_pkg::RADIX_HEX;
                        end else if (is_n) begin
                            state_next.active_radix = rpnp_pkg::RADIX_DEC;
                        end else if (is_o) begin
                            state_next.active_radix = rpnp_pkg::RADIX_OCT;
                        end else if (state_cur.active_radix == rpnp_pkg::RADIX_NONE) begin
                            // With radix zero the leading zero itself is invalid.
                            state_next.stopped = 1'b1;
                        end else begin
                            take_en = 1'b1;
                        end
                    end else begin
                        take_en = !state_cur.stopped;
                    end
                end
                default: begin
                    take_en = !state_cur.stopped;
                end
            endcase

            if (take_en) begin
                if (digit >= rpnp_pkg::DIGIT_NONE || digit >= take_radix) begin
                    state_next.stopped = 1'b1;
                end else begin
                    state_next.accumulator = rpnp_pkg::VALUE_W'(
                        state_cur.accumulator * rpnp_pkg::VALUE_W'(take_radix)
                        + rpnp_pkg::VALUE_W'(digit));
                end
            end
        end
    end

endmodule

// ----- rtl/core/radix_prefixed_number_parser_core.sv -----
// ----------------------------------------------------------------------------
// radix_prefixed_number_parser_core
// Parses an ASCII number string, one character per beat, into a 64-bit value.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one character per beat in s_tdata; a zero byte
//   ends the string. Each terminator beat yields exactly one m_ beat holding
//   the parsed value; other characters yield nothing. A leading 0x, 0n or 0o
//   selects radix 16, 10 or 8; otherwise cfg_wdata as last written through
//   cfg_wen applies, sampled on the first character of each string.
//   Write the radix only while the block is idle.
// Throughput: one character per cycle while no terminator waits for the
//   output register; the accumulator update (a 64 by 5 bit multiply-add) in rpnp_step is combinational.
// Path: a terminator accepted on the s_ channel waits in the input register
//   and is loaded into the output register when the output is free; m_tvalid
//   then rises with the result beat.
// Reset: aresetn low empties the input and output registers, clears the
//   string state and sets the default radix to 16; s_tready is low.
// Stall: while m_tvalid is held by a low m_tready, characters other than
//   the terminator still flow; a terminator waits in the input register and
//   s_tready drops until the result beat is taken.
// ----------------------------------------------------------------------------
module radix_prefixed_number_parser_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [rpnp_pkg::RADIX_W-1:0]  cfg_wdata,   // default_radix
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rpnp_pkg::CHAR_W-1:0]   s_tdata,     // [7:0] char_code
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rpnp_pkg::VALUE_W-1:0]  m_tdata      // [63:0] parsed_value
);

    logic [rpnp_pkg::RADIX_W-1:0] default_radix_reg;
    logic                         in_valid_reg;
    logic [rpnp_pkg::CHAR_W-1:0]  in_char_reg;
    rpnp_pkg::parse_state_t       state_reg;
    rpnp_pkg::parse_state_t       state_next;
    logic                         m_valid_reg;
    logic [rpnp_pkg::VALUE_W-1:0] m_data_reg;
    logic                         is_term;
    logic                         out_free;
    logic                         proc_fire;

    rpnp_step u_step (
        .char_code     (in_char_reg),
        .default_radix (default_radix_reg),
        .state_cur     (state_reg),
        .state_next    (state_next),
        .is_term       (is_term)
    );

    assign out_free  = !m_valid_reg || m_tready;
    // A terminator needs room in the output register; other characters do not.
    assign proc_fire = in_valid_reg && (!is_term || out_free);
    assign s_tready  = aresetn && (!in_valid_reg || proc_fire);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_radix_reg           <= rpnp_pkg::RADIX_RESET;
            in_valid_reg                <= 1'b0;
            m_valid_reg                 <= 1'b0;
            state_reg.accumulator       <= '0;
            state_reg.active_radix      <= rpnp_pkg::RADIX_RESET;
            state_reg.char_position     <= rpnp_pkg::POS_FIRST;
            state_reg.leading_zero_seen <= 1'b0;
            state_reg.stopped           <= 1'b0;
        end else begin
            if (cfg_wen) begin
                default_radix_reg <= cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                in_char_reg  <= s_tdata;
            end else if (proc_fire) begin
                in_valid_reg <= 1'b0;
            end
            if (proc_fire) begin
                state_reg <= state_next;
            end
            if (proc_fire && is_term) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= state_reg.accumulator;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/core/rpnp_checker.sv -----
// ----------------------------------------------------------------------------
// rpnp_checker
// Port-level assertions for the radix-prefixed number parser, bound to the
// top level.
// ----------------------------------------------------------------------------
module rpnp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [rpnp_pkg::CHAR_W-1:0]   s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rpnp_pkg::VALUE_W-1:0]  m_tdata
);

    // The output register is empty after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high right after reset");

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // A fresh result must follow an accepted terminator beat.
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |->
            $past(s_tvalid && s_tready && (s_tdata == rpnp_pkg::CHAR_TERM), 2))
        else $error("result beat without a terminator");

    // With the output register empty, the input side never stalls.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output");

endmodule

bind radix_prefixed_number_parser_core rpnp_checker u_rpnp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/radix_prefixed_number_parser_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_prefixed_number_parser_core_test
// Streams ASCII number strings into the parser and checks every parsed value
// against a cycle-free behavioral predictor. A short directed pass covers the
// prefixes, empty and lone-zero strings, invalid and non-ASCII characters and
// the radix extremes. A long random pass follows, mostly well-formed strings
// with random digits, under several default radix values and idle patterns.
// ----------------------------------------------------------------------------
module radix_prefixed_number_parser_core_test;

    localparam logic [rpnp_pkg::CHAR_W-1:0] CASE_BIT = 8'h20;  // folds upper to lower case
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 10;
    localparam int DRAIN_LIMIT    = 2000;
    localparam int RANDOM_CHARS   = 1400;
    localparam int RANDOM_BLOCKS  = 8;
    localparam int IDLE_HEAVY     = 73;
    localparam int IDLE_BOTH      = 30;
    localparam int TIME_LIMIT_NS  = 5_000_000;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wen   = 1'b0;
    logic [rpnp_pkg::RADIX_W-1:0]   cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [rpnp_pkg::CHAR_W-1:0]    s_tdata   = '0;   // [7:0] char_code
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [rpnp_pkg::VALUE_W-1:0]   m_tdata;          // [63:0] parsed_value

    radix_prefixed_number_parser_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Parser state as the block should hold it.
    logic [rpnp_pkg::RADIX_W-1:0]  radix_reg;
    logic [rpnp_pkg::VALUE_W-1:0]  value_acc;
    logic [rpnp_pkg::RADIX_W-1:0]  string_radix;
    rpnp_pkg::char_pos_t           position;
    logic                          zero_lead;
    logic                          halted;

    logic [rpnp_pkg::VALUE_W-1:0]  pending_values[$];
    int                            mismatch_count = 0;
    int                            chars_sent     = 0;
    int                            send_idle_pct  = 0;
    int                            recv_stall_pct = 0;

    function automatic logic [rpnp_pkg::RADIX_W-1:0] digit_value(
        input logic [rpnp_pkg::CHAR_W-1:0] c);
        logic [rpnp_pkg::CHAR_W-1:0] folded;
        folded = c | CASE_BIT;
        if (c >= rpnp_pkg::CHAR_ZERO && c <= rpnp_pkg::CHAR_NINE)
            return rpnp_pkg::RADIX_W'(c - rpnp_pkg::CHAR_ZERO);
        if (folded >= rpnp_pkg::CHAR_LOWER_A && folded <= rpnp_pkg::CHAR_LOWER_F)
            return rpnp_pkg::RADIX_W'(folded - rpnp_pkg::CHAR_LOWER_A
                                      + rpnp_pkg::DIGIT_ALPHA_BASE);
        return rpnp_pkg::DIGIT_NONE;
    endfunction

    task automatic clear_string();
        value_acc    = '0;
        string_radix = radix_reg;
        position     = rpnp_pkg::POS_FIRST;
        zero_lead    = 1'b0;
        halted       = 1'b0;
    endtask

    task automatic accumulate_digit(input logic [rpnp_pkg::CHAR_W-1:0] c);
        logic [rpnp_pkg::RADIX_W-1:0] d;
        d = digit_value(c);
        if (d == rpnp_pkg::DIGIT_NONE || d >= string_radix) begin
            halted = 1'b1;
        end else begin
            value_acc = value_acc * rpnp_pkg::VALUE_W'(string_radix)
                        + rpnp_pkg::VALUE_W'(d);
        end
    endtask

    // Advances the predicted state by one accepted character and queues the
    // value a terminator yields.
    task automatic parse_char(input logic [rpnp_pkg::CHAR_W-1:0] c);
        logic consumed;
        consumed = 1'b0;
        if (c == rpnp_pkg::CHAR_TERM) begin
            pending_values.push_back(value_acc);
            clear_string();
        end else if (position == rpnp_pkg::POS_FIRST) begin
            string_radix = radix_reg;
            position     = rpnp_pkg::POS_SECOND;
            if (c == rpnp_pkg::CHAR_ZERO) begin
                zero_lead = 1'b1;
            end else begin
                accumulate_digit(c);
            end
        end else begin
            if (position == rpnp_pkg::POS_SECOND) begin
                position = rpnp_pkg::POS_LATER;
                if (zero_lead) begin
                    zero_lead = 1'b0;
                    consumed  = 1'b1;
                    case (c | CASE_BIT)
                        rpnp_pkg::CHAR_LOWER_X: string_radix = rpnp_pkg::RADIX_HEX;
                        rpnp_pkg::CHAR_LOWER_N: string_radix = rpnp_pkg::RADIX_DEC;
                        rpnp_pkg::CHAR_LOWER_O: string_radix = rpnp_pkg::RADIX_OCT;
                        default: begin
                            // Without a prefix the leading zero is a digit, and only
                            // radix 0 rejects it.
                            if (string_radix == rpnp_pkg::RADIX_NONE) begin
                                halted = 1'b1;
                            end else begin
                                consumed = 1'b0;
                            end
                        end
                    endcase
                end
            end
            if (!consumed && !halted) accumulate_digit(c);
        end
    endtask

    // Called and left at a falling edge.
    task automatic send_char(input logic [rpnp_pkg::CHAR_W-1:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        parse_char(c);
        chars_sent++;
        @(negedge aclk);
    endtask

    task automatic send_string(input string t);
        int k;
        for (k = 0; k < t.len(); k++) send_char(rpnp_pkg::CHAR_W'(t[k]));
        send_char(rpnp_pkg::CHAR_TERM);
    endtask

    // The register may only change once the block has finished every string.
    task automatic set_default_radix(input logic [rpnp_pkg::RADIX_W-1:0] r);
        s_tvalid <= 1'b0;
        while (pending_values.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= r;
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        radix_reg = r;
    endtask

    function automatic logic [rpnp_pkg::CHAR_W-1:0] valid_digit_char(
        input logic [rpnp_pkg::RADIX_W-1:0] r);
        int span, d;
        span = (r > rpnp_pkg::RADIX_HEX) ? 16 : int'(r);
        if (span == 0) return rpnp_pkg::CHAR_W'($urandom_range(1, 255));
        d = $urandom_range(0, span - 1);
        if (d < 10) return rpnp_pkg::CHAR_ZERO + rpnp_pkg::CHAR_W'(d);
        if ($urandom_range(0, 1))
            return rpnp_pkg::CHAR_UPPER_A + rpnp_pkg::CHAR_W'(d) - rpnp_pkg::DIGIT_ALPHA_BASE;
        return rpnp_pkg::CHAR_LOWER_A + rpnp_pkg::CHAR_W'(d) - rpnp_pkg::DIGIT_ALPHA_BASE;
    endfunction

    task automatic send_random_string();
        logic [rpnp_pkg::RADIX_W-1:0] r;
        logic [rpnp_pkg::CHAR_W-1:0]  pc;
        int kind, len, bad_at, k;
        r    = radix_reg;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            // Noise, non-ASCII bytes included.
            len = $urandom_range(1, 8);
            for (k = 0; k < len; k++) send_char(rpnp_pkg::CHAR_W'($urandom_range(1, 255)));
        end else begin
            if (kind < 8) begin
                case ($urandom_range(0, 2))
                    0: begin pc = rpnp_pkg::CHAR_LOWER_X; r = rpnp_pkg::RADIX_HEX; end
                    1: begin pc = rpnp_pkg::CHAR_LOWER_N; r = rpnp_pkg::RADIX_DEC; end
                    default: begin pc = rpnp_pkg::CHAR_LOWER_O; r = rpnp_pkg::RADIX_OCT; end
                endcase
                if ($urandom_range(0, 1)) pc = pc & ~CASE_BIT;
                send_char(rpnp_pkg::CHAR_ZERO);
                send_char(pc);
            end else if (kind == 8) begin
                send_char(rpnp_pkg::CHAR_ZERO);
            end
            // Long strings can run past 64 bits and wrap.
            len    = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 30)
                                                 : $urandom_range(0, 12);
            bad_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len) : -1;
            for (k = 0; k < len; k++) begin
                if (k == bad_at) begin
                    send_char(rpnp_pkg::CHAR_W'($urandom_range(1, 255)));
                end else begin
                    send_char(valid_digit_char(r));
                end
            end
        end
        send_char(rpnp_pkg::CHAR_TERM);
    endtask

    task automatic test_directed_strings();
        send_string("");
        send_string("0");
        send_char(rpnp_pkg::CHAR_ZERO);
        send_char(rpnp_pkg::CHAR_LOWER_X);
        send_char(rpnp_pkg::CHAR_UPPER_F);
        send_char(8'hFF);
        send_string("1");
        send_string("$1");
        send_string("0N9");
        send_string("0o7");
    endtask

    task automatic test_radix_extremes();
        set_default_radix(rpnp_pkg::RADIX_NONE);
        send_string("05");
        send_string("0X1f");
        set_default_radix(5'd31);
        send_string("fF");
    endtask

    task automatic test_random_strings();
        logic [rpnp_pkg::RADIX_W-1:0] radix_plan [RANDOM_BLOCKS];
        int b, target;
        radix_plan = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd10, 5'd1, 5'd17, 5'd8};
        for (b = 0; b < RANDOM_BLOCKS; b++) begin
            set_default_radix(radix_plan[b]);
            case (b % 4)
                0: begin send_idle_pct = 0;          recv_stall_pct = 0;          end
                1: begin send_idle_pct = IDLE_HEAVY; recv_stall_pct = 0;          end
                2: begin send_idle_pct = 0;          recv_stall_pct = IDLE_HEAVY; end
                default: begin send_idle_pct = IDLE_BOTH; recv_stall_pct = IDLE_BOTH; end
            endcase
            target = chars_sent + RANDOM_CHARS / RANDOM_BLOCKS;
            while (chars_sent < target) send_random_string();
        end
    endtask

    task automatic finish_run();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_values.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_values.size() != 0) begin
            $error("%0d parsed values never arrived", pending_values.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("radix_prefixed_number_parser_core test passed");
        end else begin
            $display("radix_prefixed_number_parser_core test failed");
        end
        $finish;
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        logic [rpnp_pkg::VALUE_W-1:0] want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_values.size() == 0) begin
                $error("unexpected result beat: parsed_value %h", m_tdata);
                mismatch_count++;
            end else begin
                want = pending_values.pop_front();
                if (m_tdata !== want) begin
                    $error("parsed_value mismatch: expected %h, actual %h", want, m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        radix_reg = rpnp_pkg::RADIX_RESET;
        clear_string();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_strings();
        test_radix_extremes();
        test_random_strings();
        finish_run();
    end

    initial begin
        #(TIME_LIMIT_NS);
        $display("radix_prefixed_number_parser_core test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/rpnp_pkg.sv
rtl/core/rpnp_step.sv
rtl/core/radix_prefixed_number_parser_core.sv
rtl/core/rpnp_checker.sv
tb/radix_prefixed_number_parser_core_test.sv
